FILE: rtl/core/smae_pkg.sv
// Package for the square matrix arithmetic engine.
// Holds the widths, command and operation codes and the controller-to-datapath structs.
// No dependencies.
package smae_pkg;

    localparam int MAX_DIM  = 8;
    localparam int DIM_W    = 3;
    localparam int ADDR_W   = 2 * DIM_W;
    localparam int DEPTH    = MAX_DIM * MAX_DIM;
    localparam int ELEM_W   = 16;
    localparam int PROD_W   = 2 * ELEM_W;
    localparam int VAL_W    = 35;
    localparam int SIZE_W   = 4;
    localparam int CMD_W    = 2;
    localparam int OP_W     = 2;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 4;

    localparam logic [CMD_W-1:0] CMD_WRITE_A = 2'd0;
    localparam logic [CMD_W-1:0] CMD_WRITE_B = 2'd1;
    localparam logic [CMD_W-1:0] CMD_COMPUTE = 2'd2;

    localparam logic [OP_W-1:0] OP_ADD       = 2'd0;
    localparam logic [OP_W-1:0] OP_SUB       = 2'd1;
    localparam logic [OP_W-1:0] OP_TRANSPOSE = 2'd2;
    localparam logic [OP_W-1:0] OP_MULTIPLY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_MATRIX_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OPERATION   = 2'd1;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // Pipeline stages between a read being issued and its result strobe, less one.
    localparam int DRAIN_CYCLES = 2;
    localparam int DRAIN_W      = 2;

    // Load word strobes from the controller.
    typedef struct packed {
        logic wr_a;
        logic wr_b;
    } t_wr_cmd;

    // One read-and-accumulate step issued by the controller.
    typedef struct packed {
        logic             rd_en;
        logic             first;
        logic             emit;
        logic             last;
        logic [OP_W-1:0]  op;
        logic [DIM_W-1:0] row;
        logic [DIM_W-1:0] col;
        logic [DIM_W-1:0] k;
    } t_step_cmd;

endpackage

FILE: rtl/core/smae_ctrl.sv
// Controller of the square matrix arithmetic engine: configuration registers,
// load word decoding and the row/column/term sequencer. Depends on smae_pkg.
module smae_ctrl import smae_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [CMD_W-1:0]      i_command,
    input  logic                  i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output logic                  o_busy,
    output t_wr_cmd               o_wr,
    output t_step_cmd             o_step
);

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_RUN   = 3'b010,
        ST_DRAIN = 3'b100
    } t_state;

    t_state             r_state, n_state;
    logic [SIZE_W-1:0]  r_size;
    logic [OP_W-1:0]    r_op_cfg;
    logic [OP_W-1:0]    r_op, n_op;
    logic [DIM_W-1:0]   r_last_idx, n_last_idx;
    logic [DIM_W-1:0]   r_row, n_row;
    logic [DIM_W-1:0]   r_col, n_col;
    logic [DIM_W-1:0]   r_k, n_k;
    logic [DRAIN_W-1:0] r_drain, n_drain;

    logic              accept;
    logic [SIZE_W-1:0] eff_size;
    logic              step_emit;

    assign o_busy = (r_state != ST_IDLE);
    assign accept = i_start && !o_busy;

    // A size above the array acts as the full array.
    assign eff_size = (r_size > SIZE_W'(MAX_DIM)) ? SIZE_W'(MAX_DIM) : r_size;

    assign o_wr.wr_a = accept && (i_command == CMD_WRITE_A);
    assign o_wr.wr_b = accept && (i_command == CMD_WRITE_B);

    assign step_emit = (r_op != OP_MULTIPLY) || (r_k == r_last_idx);

    assign o_step.rd_en = (r_state == ST_RUN);
    assign o_step.first = (r_k == '0);
    assign o_step.emit  = step_emit;
    assign o_step.last  = step_emit && (r_row == r_last_idx) && (r_col == r_last_idx);
    assign o_step.op    = r_op;
    assign o_step.row   = r_row;
    assign o_step.col   = r_col;
    assign o_step.k     = r_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_size   <= SIZE_RESET;
            r_op_cfg <= OP_ADD;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == CFG_MATRIX_SIZE) begin
                r_size <= i_cfg_data;
            end else if (i_cfg_index == CFG_OPERATION) begin
                r_op_cfg <= i_cfg_data[OP_W-1:0];
            end
        end
    end

    always_comb begin
        n_state    = r_state;
        n_op       = r_op;
        n_last_idx = r_last_idx;
        n_row      = r_row;
        n_col      = r_col;
        n_k        = r_k;
        n_drain    = r_drain;
        unique case (r_state)
            ST_IDLE: begin
                if (accept && (i_command == CMD_COMPUTE) && (eff_size != '0)) begin
                    n_state    = ST_RUN;
                    n_op       = r_op_cfg;
                    n_last_idx = DIM_W'(eff_size - SIZE_W'(1));
                    n_row      = '0;
                    n_col      = '0;
                    n_k        = '0;
                end
            end
            ST_RUN: begin
                if (!step_emit) begin
                    n_k = r_k + DIM_W'(1);
                end else begin
                    n_k = '0;
                    if (r_col != r_last_idx) begin
                        n_col = r_col + DIM_W'(1);
                    end else begin
                        n_col = '0;
                        if (r_row != r_last_idx) begin
                            n_row = r_row + DIM_W'(1);
                        end else begin
                            n_state = ST_DRAIN;
                            n_drain = DRAIN_W'(DRAIN_CYCLES - 1);
                        end
                    end
                end
            end
            ST_DRAIN: begin
                if (r_drain == '0) begin
                    n_state = ST_IDLE;
                end else begin
                    n_drain = r_drain - DRAIN_W'(1);
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_op       <= OP_ADD;
            r_last_idx <= '0;
            r_row      <= '0;
            r_col      <= '0;
            r_k        <= '0;
            r_drain    <= '0;
        end else begin
            r_state    <= n_state;
            r_op       <= n_op;
            r_last_idx <= n_last_idx;
            r_row      <= n_row;
            r_col      <= n_col;
            r_k        <= n_k;
            r_drain    <= n_drain;
        end
    end

endmodule

FILE: rtl/core/smae_dp.sv
// Datapath of the square matrix arithmetic engine: the A and B element memories,
// the add/subtract/transpose/multiply term stage and the accumulator. Depends on smae_pkg.
module smae_dp import smae_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  t_wr_cmd                  i_wr,
    input  t_step_cmd                i_step,
    input  logic [DIM_W-1:0]         i_wr_row,
    input  logic [DIM_W-1:0]         i_wr_col,
    input  logic signed [ELEM_W-1:0] i_wr_value,
    output logic                     o_valid,
    output logic signed [VAL_W-1:0]  o_value,
    output logic [DIM_W-1:0]         o_row,
    output logic [DIM_W-1:0]         o_col,
    output logic                     o_last
);

    logic signed [ELEM_W-1:0] mem_a [0:DEPTH-1];
    logic signed [ELEM_W-1:0] mem_b [0:DEPTH-1];

    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_addr_a;
    logic [ADDR_W-1:0] rd_addr_b;

    logic signed [ELEM_W-1:0] r_rd_a;
    logic signed [ELEM_W-1:0] r_rd_b;
    t_step_cmd                r_s1;
    t_step_cmd                r_s2;
    logic                     r_v1;
    logic                     r_v2;
    logic signed [VAL_W-1:0]  r_term, n_term;
    logic signed [PROD_W-1:0] prod;
    logic signed [VAL_W-1:0]  r_acc;
    logic                     r_out_valid;
    logic [DIM_W-1:0]         r_out_row;
    logic [DIM_W-1:0]         r_out_col;
    logic                     r_out_last;

    assign wr_addr = {i_wr_row, i_wr_col};

    // Transpose reads A with row and column swapped; multiply walks the row of A and the column of B along k.
    always_comb begin
        unique case (i_step.op)
            OP_TRANSPOSE: begin
                rd_addr_a = {i_step.col, i_step.row};
                rd_addr_b = {i_step.row, i_step.col};
            end
            OP_MULTIPLY: begin
                rd_addr_a = {i_step.row, i_step.k};
                rd_addr_b = {i_step.k, i_step.col};
            end
            default: begin
                rd_addr_a = {i_step.row, i_step.col};
                rd_addr_b = {i_step.row, i_step.col};
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_a) begin
            mem_a[wr_addr] <= i_wr_value;
        end
        r_rd_a <= mem_a[rd_addr_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.wr_b) begin
            mem_b[wr_addr] <= i_wr_value;
        end
        r_rd_b <= mem_b[rd_addr_b];
    end

    assign prod = r_rd_a * r_rd_b;

    always_comb begin
        unique case (r_s1.op)
            OP_ADD:       n_term = VAL_W'(r_rd_a) + VAL_W'(r_rd_b);
            OP_SUB:       n_term = VAL_W'(r_rd_a) - VAL_W'(r_rd_b);
            OP_TRANSPOSE: n_term = VAL_W'(r_rd_a);
            default:      n_term = VAL_W'(prod);
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_term <= n_term;
        r_s1   <= i_step;
        r_s2   <= r_s1;
        if (r_v2) begin
            r_acc      <= r_s2.first ? r_term : r_acc + r_term;
            r_out_row  <= r_s2.row;
            r_out_col  <= r_s2.col;
            r_out_last <= r_s2.last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_v1        <= i_step.rd_en;
            r_v2        <= r_v1;
            r_out_valid <= r_v2 && r_s2.emit;
        end
    end

    assign o_valid = r_out_valid;
    assign o_value = r_acc;
    assign o_row   = r_out_row;
    assign o_col   = r_out_col;
    assign o_last  = r_out_last;

endmodule

FILE: rtl/core/square_matrix_arith_engine.sv
// Square matrix arithmetic engine: element loads are accepted back to back while not busy.
// A compute word keeps busy high through one step per element (add, subtract, transpose)
// or per term (multiply, one multiply-accumulate per cycle through the memories), then drain.
// Results stream one word per element; for add, subtract and transpose the first strobe
// follows the compute word through the sequencer, read, term and accumulator registers.
// Synchronous active-low reset sets size 8 and add; the matrix memories are not cleared.
module square_matrix_arith_engine import smae_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic [CMD_W-1:0]         i_command,
    input  logic [DIM_W-1:0]         i_row_index,
    input  logic [DIM_W-1:0]         i_column_index,
    input  logic signed [ELEM_W-1:0] i_element_value,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                     o_result_strobe,
    output logic signed [VAL_W-1:0]  o_result_value,
    output logic [DIM_W-1:0]         o_result_row,
    output logic [DIM_W-1:0]         o_result_column,
    output logic                     o_last_element
);

    t_wr_cmd   wr_cmd;
    t_step_cmd step_cmd;

    assign o_cfg_ready = 1'b1;

    smae_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_command   (i_command),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_busy      (o_busy),
        .o_wr        (wr_cmd),
        .o_step      (step_cmd)
    );

    smae_dp u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_wr       (wr_cmd),
        .i_step     (step_cmd),
        .i_wr_row   (i_row_index),
        .i_wr_col   (i_column_index),
        .i_wr_value (i_element_value),
        .o_valid    (o_result_strobe),
        .o_value    (o_result_value),
        .o_row      (o_result_row),
        .o_col      (o_result_column),
        .o_last     (o_last_element)
    );

endmodule

FILE: bench/square_matrix_arith_engine_test.sv
`timescale 1ns / 1ps
// Self-checking bench for square_matrix_arith_engine: element loads, computes and register writes,
// predicted cycle-free and compared word by word against the result stream.
// Depends on smae_pkg and the engine RTL only.
module square_matrix_arith_engine_test;
    import smae_pkg::*;

    localparam logic [CMD_W-1:0]     CMD_UNUSED  = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;
    localparam int STALL_LIMIT  = 2000;
    localparam int RANDOM_WORDS = 48;

    typedef struct packed {
        logic [CMD_W-1:0]         command;
        logic [DIM_W-1:0]         row;
        logic [DIM_W-1:0]         col;
        logic signed [ELEM_W-1:0] value;
    } t_load_word;

    typedef struct packed {
        logic signed [VAL_W-1:0] value;
        logic [DIM_W-1:0]        row;
        logic [DIM_W-1:0]        col;
        logic                    last;
    } t_matrix_element;

    logic                     i_clk;
    logic                     i_rst_n;
    logic                     i_start;
    logic                     o_busy;
    logic [CMD_W-1:0]         i_command;
    logic [DIM_W-1:0]         i_row_index;
    logic [DIM_W-1:0]         i_column_index;
    logic signed [ELEM_W-1:0] i_element_value;
    logic                     i_cfg_valid;
    logic                     o_cfg_ready;
    logic [CFG_IDX_W-1:0]     i_cfg_index;
    logic [CFG_DATA_W-1:0]    i_cfg_data;
    logic                     o_result_strobe;
    logic signed [VAL_W-1:0]  o_result_value;
    logic [DIM_W-1:0]         o_result_row;
    logic [DIM_W-1:0]         o_result_column;
    logic                     o_last_element;

    t_load_word      pending_words[$];
    t_matrix_element expected_elements[$];

    // Shadow of the engine as the bench predicts it.
    logic signed [ELEM_W-1:0] store_a [DEPTH];
    logic signed [ELEM_W-1:0] store_b [DEPTH];
    logic [SIZE_W-1:0]        reg_size;
    logic [OP_W-1:0]          reg_op;

    // What the stimulus side believes, used to avoid reading unloaded entries and to aim loads.
    bit                       loaded_a [DEPTH];
    bit                       loaded_b [DEPTH];
    int                       plan_n;
    logic [OP_W-1:0]          plan_op;

    bit word_taken;
    bit gaps_enabled;
    int gap_left;
    int words_queued;
    int words_taken;
    int load_count;
    int error_count;
    int quiet_cycles;

    square_matrix_arith_engine uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_start         (i_start),
        .o_busy          (o_busy),
        .i_command       (i_command),
        .i_row_index     (i_row_index),
        .i_column_index  (i_column_index),
        .i_element_value (i_element_value),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result_strobe (o_result_strobe),
        .o_result_value  (o_result_value),
        .o_result_row    (o_result_row),
        .o_result_column (o_result_column),
        .o_last_element  (o_last_element)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic signed [VAL_W-1:0] element_result(input int r, input int c,
                                                              input int n);
        longint acc;
        acc = 0;
        case (reg_op)
            OP_ADD:       acc = store_a[r*MAX_DIM+c] + store_b[r*MAX_DIM+c];
            OP_SUB:       acc = store_a[r*MAX_DIM+c] - store_b[r*MAX_DIM+c];
            OP_TRANSPOSE: acc = store_a[c*MAX_DIM+r];
            default: begin
                for (int k = 0; k < n; k++)
                    acc += store_a[r*MAX_DIM+k] * store_b[k*MAX_DIM+c];
            end
        endcase
        return VAL_W'(acc);
    endfunction

    task automatic predict_word(input logic [CMD_W-1:0] cmd, input logic [DIM_W-1:0] row,
                                input logic [DIM_W-1:0] col,
                                input logic signed [ELEM_W-1:0] val);
        int n;
        t_matrix_element elem;
        case (cmd)
            CMD_WRITE_A: store_a[{row, col}] = val;
            CMD_WRITE_B: store_b[{row, col}] = val;
            CMD_COMPUTE: begin
                n = (reg_size > MAX_DIM) ? MAX_DIM : int'(reg_size);
                for (int r = 0; r < n; r++) begin
                    for (int c = 0; c < n; c++) begin
                        elem.value = element_result(r, c, n);
                        elem.row   = DIM_W'(r);
                        elem.col   = DIM_W'(c);
                        elem.last  = (r == n - 1) && (c == n - 1);
                        expected_elements.push_back(elem);
                    end
                end
            end
            default: ;
        endcase
    endtask

    // Monitor: register writes, accepted words and the result stream, all seen at the rising edge.
    always @(posedge i_clk) begin : monitor
        t_matrix_element want;
        if (!i_rst_n) begin
            reg_size = SIZE_RESET;
            reg_op   = OP_ADD;
        end else begin
            if (o_result_strobe) begin
                if (expected_elements.size() == 0) begin
                    $display("%0t: unexpected result value %0d row %0d col %0d last %0b",
                             $time, o_result_value, o_result_row, o_result_column,
                             o_last_element);
                    error_count++;
                end else begin
                    want = expected_elements.pop_front();
                    if (o_result_value !== want.value) begin
                        $display("%0t: value expected %0d actual %0d", $time, want.value,
                                 o_result_value);
                        error_count++;
                    end
                    if (o_result_row !== want.row) begin
                        $display("%0t: row expected %0d actual %0d", $time, want.row,
                                 o_result_row);
                        error_count++;
                    end
                    if (o_result_column !== want.col) begin
                        $display("%0t: column expected %0d actual %0d", $time, want.col,
                                 o_result_column);
                        error_count++;
                    end
                    if (o_last_element !== want.last) begin
                        $display("%0t: last expected %0b actual %0b", $time, want.last,
                                 o_last_element);
                        error_count++;
                    end
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == CFG_MATRIX_SIZE)
                    reg_size = i_cfg_data;
                else if (i_cfg_index == CFG_OPERATION)
                    reg_op = i_cfg_data[OP_W-1:0];
            end
            if (i_start && !o_busy) begin
                predict_word(i_command, i_row_index, i_column_index, i_element_value);
                words_taken++;
                word_taken = 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_start && !o_busy) || o_result_strobe || (i_cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("== FAIL ==");
            $finish;
        end
    end

    // Driver: presents the oldest pending word and holds it until it is taken.
    always @(negedge i_clk) begin : driver
        logic next_start;
        if (word_taken) begin
            word_taken = 1'b0;
            void'(pending_words.pop_front());
            if (gaps_enabled && $urandom_range(3) == 0)
                gap_left = $urandom_range(8, 1);
        end
        next_start = 1'b0;
        if (gap_left > 0) begin
            gap_left--;
        end else if (pending_words.size() > 0) begin
            next_start      = 1'b1;
            i_command       <= pending_words[0].command;
            i_row_index     <= pending_words[0].row;
            i_column_index  <= pending_words[0].col;
            i_element_value <= pending_words[0].value;
        end
        i_start <= next_start;
    end

    function automatic logic [ELEM_W-1:0] random_element();
        case ($urandom_range(7))
            0:       return 16'h7fff;
            1:       return 16'h8000;
            default: return ELEM_W'($urandom);
        endcase
    endfunction

    task automatic queue_word(input logic [CMD_W-1:0] cmd, input int r, input int c,
                              input logic [ELEM_W-1:0] val);
        pending_words.push_back('{command: cmd, row: DIM_W'(r), col: DIM_W'(c), value: val});
        words_queued++;
        if (cmd != CMD_UNUSED)
            load_count++;
        if (cmd == CMD_WRITE_A)
            loaded_a[r*MAX_DIM+c] = 1'b1;
        else if (cmd == CMD_WRITE_B)
            loaded_b[r*MAX_DIM+c] = 1'b1;
    endtask

    // Loads whatever the coming compute would read that has never been written, then the compute.
    task automatic queue_compute();
        for (int r = 0; r < plan_n; r++) begin
            for (int c = 0; c < plan_n; c++) begin
                if (!loaded_a[r*MAX_DIM+c])
                    queue_word(CMD_WRITE_A, r, c, random_element());
                if (plan_op != OP_TRANSPOSE && !loaded_b[r*MAX_DIM+c])
                    queue_word(CMD_WRITE_B, r, c, random_element());
            end
        end
        queue_word(CMD_COMPUTE, $urandom_range(7), $urandom_range(7), ELEM_W'($urandom));
    endtask

    task automatic wait_drained();
        do @(negedge i_clk);
        while (words_taken != words_queued || expected_elements.size() != 0 || o_busy);
        repeat (DRAIN_CYCLES + 4) @(negedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk);
        while (!o_cfg_ready);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic set_registers(input int size, input logic [OP_W-1:0] op);
        wait_drained();
        write_register(CFG_MATRIX_SIZE, CFG_DATA_W'(size));
        write_register(CFG_OPERATION, {2'($urandom_range(3)), op});
        plan_n  = (size > MAX_DIM) ? MAX_DIM : size;
        plan_op = op;
    endtask

    initial begin : stimulus
        int burst;
        int pick;
        i_rst_n         = 1'b0;
        i_start         = 1'b0;
        i_command       = CMD_WRITE_A;
        i_row_index     = '0;
        i_column_index  = '0;
        i_element_value = '0;
        i_cfg_valid     = 1'b0;
        i_cfg_index     = CFG_MATRIX_SIZE;
        i_cfg_data      = '0;
        gaps_enabled    = 1'b1;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: overflow-free add and subtract extremes on one element, an unused word, a 2x2 transpose.
        set_registers(1, OP_ADD);
        queue_word(CMD_WRITE_A, 0, 0, 16'h7fff);
        queue_word(CMD_WRITE_B, 0, 0, 16'h7fff);
        queue_compute();
        queue_word(CMD_WRITE_A, 0, 0, 16'h8000);
        queue_word(CMD_WRITE_B, 0, 0, 16'h8000);
        queue_compute();
        queue_word(CMD_UNUSED, 7, 7, 16'hffff);
        queue_word(CMD_WRITE_A, 7, 7, 16'h0000);
        set_registers(1, OP_SUB);
        queue_word(CMD_WRITE_A, 0, 0, 16'h7fff);
        queue_word(CMD_WRITE_B, 0, 0, 16'h8000);
        queue_compute();
        queue_word(CMD_WRITE_A, 0, 0, 16'h8000);
        queue_word(CMD_WRITE_B, 0, 0, 16'h7fff);
        queue_compute();
        set_registers(2, OP_TRANSPOSE);
        queue_compute();

        // A zero size emits nothing; writes to the spare indexes must leave both registers alone.
        set_registers(0, OP_MULTIPLY);
        queue_compute();
        wait_drained();
        write_register(CFG_SPARE_2, CFG_DATA_W'($urandom));
        write_register(CFG_SPARE_3, CFG_DATA_W'($urandom));
        queue_compute();

        // An oversized setting acts as the full eight; all-negative inputs give the largest sum.
        set_registers(15, OP_MULTIPLY);
        for (int r = 0; r < MAX_DIM; r++) begin
            for (int c = 0; c < MAX_DIM; c++) begin
                queue_word(CMD_WRITE_A, r, c, 16'h8000);
                queue_word(CMD_WRITE_B, r, c, 16'h8000);
            end
        end
        queue_compute();
        for (int k = 0; k < MAX_DIM; k++)
            queue_word(CMD_WRITE_B, k, 0, 16'h7fff);
        queue_compute();
        set_registers(8, OP_ADD);
        queue_compute();
        set_registers(8, OP_SUB);
        queue_compute();
        set_registers(8, OP_TRANSPOSE);
        queue_compute();

        // Random phases: mostly loads into the area in use, some computes, a little noise.
        load_count = 0;
        while (load_count < RANDOM_WORDS) begin
            if (load_count > RANDOM_WORDS * 4 / 5)
                gaps_enabled = 1'b0;
            else
                gaps_enabled = ($urandom_range(3) != 0);
            case ($urandom_range(9))
                0:       set_registers(0, OP_W'($urandom_range(3)));
                1:       set_registers(SIZE_W'($urandom_range(15, 8)), OP_W'($urandom_range(3)));
                2, 3:    set_registers(SIZE_W'($urandom_range(7, 5)), OP_W'($urandom_range(3)));
                default: set_registers(SIZE_W'($urandom_range(4, 1)), OP_W'($urandom_range(3)));
            endcase
            burst = $urandom_range(25, 5);
            repeat (burst) begin
                pick = $urandom_range(15);
                if (pick == 0)
                    queue_word(CMD_UNUSED, $urandom_range(7), $urandom_range(7),
                               ELEM_W'($urandom));
                else if (pick == 1 || plan_n == 0)
                    queue_word($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A,
                               $urandom_range(7), $urandom_range(7), random_element());
                else if (pick <= 3)
                    queue_compute();
                else
                    queue_word($urandom_range(1) ? CMD_WRITE_B : CMD_WRITE_A,
                               $urandom_range(plan_n - 1), $urandom_range(plan_n - 1),
                               random_element());
            end
            queue_compute();
        end

        wait_drained();
        if (error_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
